[sv/pip_pkg.sv]
`timescale 1ns / 1ps

package pip_pkg;

    // Operation codes carried on the input tuser.
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Result layout: inside flag, vertex count, truncation flag.
    localparam int VCOUNT_W    = 7;
    localparam int OUT_TDATA_W = 16;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } pip_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic append;
        logic query;
        logic issue;
        logic load_out;
    } pip_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic last_issue;
        logic pipe_empty;
        logic out_busy;
    } pip_status_t;

endpackage

[sv/pip_ram.sv]
`timescale 1ns / 1ps

module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/pip_ctrl.sv]
`timescale 1ns / 1ps

module pip_ctrl
    import pip_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic [1:0]  op,
    input  pip_status_t status,
    output logic        s_tready,
    output pip_cmd_t    cmd
);

    pip_state_t state_reg;
    pip_state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (op)
                        OP_CLEAR:  cmd.clear  = 1'b1;
                        OP_APPEND: cmd.append = 1'b1;
                        OP_QUERY:
                        begin
                            cmd.query  = 1'b1;
                            state_next = status.count_zero ? ST_DONE : ST_RUN;
                        end
                        default:   ;
                    endcase
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                if (status.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.pipe_empty)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/pip_datapath.sv]
`timescale 1ns / 1ps

module pip_datapath
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pip_cmd_t                     cmd,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic                         m_tready,
    output pip_status_t                  status,
    output logic                         m_tvalid,
    output logic                         inside_res,
    output logic [VCOUNT_W-1:0]          vertex_count,
    output logic                         truncated
);

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int DW    = COORD_BITS + 1;
    localparam int PW    = 2 * DW;
    localparam int VW    = 2 * COORD_BITS;

    // Polygon bookkeeping.
    logic [CNT_W-1:0]             count_reg;
    logic                         ovf_reg;
    logic                         full;

    // Query point and read sequencing.
    logic signed [COORD_BITS-1:0] px_reg;
    logic signed [COORD_BITS-1:0] py_reg;
    logic [CNT_W-1:0]             k_reg;
    logic [CNT_W-1:0]             rd_idx;
    logic                         r_vld_reg;
    logic                         r_first_reg;
    logic [VW-1:0]                rd_data;
    logic [VW-1:0]                prev_reg;

    // Edge pipeline.
    logic signed [COORD_BITS-1:0] xi, yi, xj, yj;
    logic                         s1_vld_reg, s1_cond_reg;
    logic signed [DW-1:0]         dy_reg, lhs_reg, rhsa_reg, rhsb_reg;
    logic                         s2_vld_reg, s2_cond_reg, s2_neg_reg;
    logic signed [PW-1:0]         p1_reg, p2_reg;
    logic                         less;
    logic                         parity_reg;

    // Result register.
    logic                         out_vld_reg;
    logic                         out_inside_reg;
    logic [VCOUNT_W-1:0]          out_cnt_reg;
    logic                         out_trunc_reg;
    logic [CNT_W+VCOUNT_W-1:0]    cnt_ext;

    assign full = (count_reg == CNT_W'(MAX_VERTICES));

    // The first read fetches the last vertex, then vertices 0 .. n-1 follow.
    assign rd_idx = (k_reg == '0) ? (count_reg - CNT_W'(1)) : (k_reg - CNT_W'(1));

    pip_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.append && !full),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({coord_y, coord_x}),
        .rd_en   (cmd.issue),
        .rd_addr (rd_idx[AW-1:0]),
        .rd_data (rd_data)
    );

    // Vertex i is the one just read, vertex j the one read before it.
    assign xi = rd_data[COORD_BITS-1:0];
    assign yi = rd_data[VW-1:COORD_BITS];
    assign xj = prev_reg[COORD_BITS-1:0];
    assign yj = prev_reg[VW-1:COORD_BITS];

    // Crossing compare with the sign of dy folded into the direction.
    assign less = s2_neg_reg ? (p2_reg < p1_reg) : (p1_reg < p2_reg);

    // Status to the controller.
    assign status.count_zero = (count_reg == '0);
    assign status.last_issue = (k_reg == count_reg);
    assign status.pipe_empty = !r_vld_reg && !s1_vld_reg && !s2_vld_reg;
    assign status.out_busy   = out_vld_reg && !m_tready;

    // Polygon count, overflow flag, control bits of the pipeline, parity and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            k_reg       <= '0;
            r_vld_reg   <= 1'b0;
            r_first_reg <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            parity_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (cmd.append)
            begin
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end

            if (cmd.query)
            begin
                k_reg <= '0;
            end
            else if (cmd.issue)
            begin
                k_reg <= k_reg + CNT_W'(1);
            end

            r_vld_reg   <= cmd.issue;
            r_first_reg <= (k_reg == '0);
            s1_vld_reg  <= r_vld_reg && !r_first_reg;
            s2_vld_reg  <= s1_vld_reg;

            if (cmd.query)
            begin
                parity_reg <= 1'b0;
            end
            else if (s2_vld_reg && s2_cond_reg && less)
            begin
                parity_reg <= !parity_reg;
            end

            if (cmd.load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the query and the edge pipeline.
    always_ff @(posedge clk)
    begin
        if (cmd.query)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        if (r_vld_reg)
        begin
            prev_reg <= rd_data;
        end

        // Stage 1: edge straddle test and differences.
        s1_cond_reg <= (yi > py_reg) != (yj > py_reg);
        dy_reg      <= DW'(yj) - DW'(yi);
        lhs_reg     <= DW'(px_reg) - DW'(xi);
        rhsa_reg    <= DW'(xj) - DW'(xi);
        rhsb_reg    <= DW'(py_reg) - DW'(yi);

        // Stage 2: the two cross products.
        s2_cond_reg <= s1_cond_reg;
        s2_neg_reg  <= dy_reg[DW-1];
        p1_reg      <= PW'(lhs_reg) * PW'(dy_reg);
        p2_reg      <= PW'(rhsa_reg) * PW'(rhsb_reg);
    end

    assign cnt_ext = {{VCOUNT_W{1'b0}}, count_reg};

    // Result register, loaded once the query is finished.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_inside_reg <= parity_reg;
            out_cnt_reg    <= cnt_ext[VCOUNT_W-1:0];
            out_trunc_reg  <= ovf_reg;
        end
    end

    assign m_tvalid     = out_vld_reg;
    assign inside_res   = out_inside_reg;
    assign vertex_count = out_cnt_reg;
    assign truncated    = out_trunc_reg;

endmodule

[sv/point_in_polygon_test_top.sv]
`timescale 1ns / 1ps

// Point-in-polygon test, even-odd ray casting over a stored polygon.
// Input stream: tuser carries the operation (clear, append vertex, query),
// tdata carries the vertex or query point as x in the low half and y above.
// Clear and append produce no transaction; an append to a full polygon is
// dropped and sets the truncation flag.
// A query reads one stored vertex a cycle from the vertex store and runs one
// edge a cycle through a three-stage compare pipeline before its result is
// loaded; an empty polygon, which answers outside, goes straight to the
// result load without reading the store.
// Input is taken again from the cycle after the load, so a new query is
// accepted only once the previous one has loaded its result.
// The output stream carries one transaction per query: the inside flag, the
// vertex count and the truncation flag.
// The result sits in an output register; the block keeps accepting clears,
// appends and a new query while it waits, and a finished query waits for the
// register to empty when the receiver stalls.
// Reset empties the polygon and clears the truncation flag; the vertex store
// itself is not cleared and needs no clearing pass.
module point_in_polygon_test_top
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0: coord_x, coord_y, zero fill.
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]    s_tdata,
    // Fields from bit 0: operation.
    input  logic [1:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // Fields from bit 0: inside_res, vertex_count, truncated, zero fill.
    output logic [OUT_TDATA_W-1:0]               m_tdata
);

    pip_cmd_t                     cmd;
    pip_status_t                  status;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic                         inside_res;
    logic [VCOUNT_W-1:0]          vertex_count;
    logic                         truncated;

    assign coord_x = s_tdata[COORD_BITS-1:0];
    assign coord_y = s_tdata[2*COORD_BITS-1:COORD_BITS];

    pip_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .op       (s_tuser),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    pip_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .m_tready     (m_tready),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .inside_res   (inside_res),
        .vertex_count (vertex_count),
        .truncated    (truncated)
    );

    assign m_tdata = {{(OUT_TDATA_W-VCOUNT_W-2){1'b0}}, truncated, vertex_count, inside_res};

    // At most one controller command is active per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clear, cmd.append, cmd.query, cmd.issue, cmd.load_out}))
        else $error("more than one command at once");

    // No input transaction is taken while edges are being read.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> !s_tready)
        else $error("input accepted during a query");

    // A result is loaded only into a free output register and then shows up.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid || m_tready) ##1 m_tvalid)
        else $error("result overwrote a pending transaction or was lost");

    // A query never starts while the edge pipeline still holds work.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.query |-> status.pipe_empty)
        else $error("query started with a busy pipeline");

endmodule

[dv/point_in_polygon_checker.sv]
`timescale 1ns / 1ps

// Watches both streams of the point-in-polygon block, keeps its own copy of
// the polygon, predicts the answer of every accepted query and compares each
// result transaction against the oldest pending prediction.
module point_in_polygon_checker
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    // Fields from bit 0: coord_x, coord_y, zero fill.
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // Fields from bit 0: operation.
    input  logic [1:0]                        s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0: inside_res, vertex_count, truncated, zero fill.
    input  logic [OUT_TDATA_W-1:0]            m_tdata,
    output int                                mismatch_count,
    output int                                pending_count,
    output int                                results_seen,
    output int                                inside_seen,
    output int                                truncated_seen
);

    // One query answer; the first member sits in the highest bits.
    typedef struct packed {
        logic                truncated;
        logic [VCOUNT_W-1:0] count;
        logic                is_inside;
    } pip_result_t;

    logic signed [COORD_BITS-1:0] poly_x [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] poly_y [MAX_VERTICES];
    int                           poly_count;
    logic                         poly_truncated;
    pip_result_t                  expected_answers [$];

    // Even-odd crossing count of a ray cast to the right of the query point.
    // The crossing abscissa is compared exactly by cross-multiplication,
    // with the inequality flipped when the edge runs downward.
    function automatic logic ray_parity_inside(input logic signed [COORD_BITS-1:0] qx,
                                               input logic signed [COORD_BITS-1:0] qy);
        logic   parity;
        int     j;
        longint xi, yi, xj, yj, dy, lhs, rhs;
        parity = 1'b0;
        j      = poly_count - 1;
        for (int i = 0; i < poly_count; i++)
        begin
            xi = poly_x[i];
            yi = poly_y[i];
            xj = poly_x[j];
            yj = poly_y[j];
            if ((yi > longint'(qy)) != (yj > longint'(qy)))
            begin
                dy  = yj - yi;
                lhs = (longint'(qx) - xi) * dy;
                rhs = (xj - xi) * (longint'(qy) - yi);
                if (dy > 0 ? (lhs < rhs) : (rhs < lhs))
                    parity = ~parity;
            end
            j = i;
        end
        return parity;
    endfunction

    // Results are checked before the input side is applied; a query never
    // answers in the cycle it is accepted.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        pip_result_t                  got;
        pip_result_t                  want;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        if (!rst_n)
        begin
            poly_count     = 0;
            poly_truncated = 1'b0;
            expected_answers.delete();
            mismatch_count = 0;
            pending_count  = 0;
            results_seen   = 0;
            inside_seen    = 0;
            truncated_seen = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = pip_result_t'(m_tdata[VCOUNT_W+1:0]);
                results_seen++;
                if (got.is_inside)
                    inside_seen++;
                if (got.truncated)
                    truncated_seen++;
                if (expected_answers.size() == 0)
                begin
                    mismatch_count++;
                    $error("result transaction with no query pending, tdata %h", m_tdata);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (got.is_inside !== want.is_inside)
                    begin
                        mismatch_count++;
                        $error("inside_res: expected %0d, actual %0d",
                               want.is_inside, got.is_inside);
                    end
                    if (got.count !== want.count)
                    begin
                        mismatch_count++;
                        $error("vertex_count: expected %0d, actual %0d", want.count, got.count);
                    end
                    if (got.truncated !== want.truncated)
                    begin
                        mismatch_count++;
                        $error("truncated: expected %0d, actual %0d",
                               want.truncated, got.truncated);
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                cx = s_tdata[COORD_BITS-1:0];
                cy = s_tdata[2*COORD_BITS-1:COORD_BITS];
                case (s_tuser)
                    OP_CLEAR:
                    begin
                        poly_count     = 0;
                        poly_truncated = 1'b0;
                    end
                    OP_APPEND:
                    begin
                        if (poly_count < MAX_VERTICES)
                        begin
                            poly_x[poly_count] = cx;
                            poly_y[poly_count] = cy;
                            poly_count++;
                        end
                        else
                            poly_truncated = 1'b1;
                    end
                    OP_QUERY:
                    begin
                        want.is_inside = ray_parity_inside(cx, cy);
                        want.count     = poly_count[VCOUNT_W-1:0];
                        want.truncated = poly_truncated;
                        expected_answers.push_back(want);
                    end
                    default:
                    begin
                        // The unused code leaves the polygon as it is.
                    end
                endcase
            end
            pending_count = expected_answers.size();
        end
    end

endmodule

[dv/point_in_polygon_test_top_tb.sv]
`timescale 1ns / 1ps

module point_in_polygon_test_top_tb;
    import pip_pkg::*;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 16;
    localparam int IN_W         = ((2*COORD_BITS+7)/8)*8;
    localparam int TARGET_ITEMS = 1600;
    localparam int HOLD_CYCLES  = 3000;
    localparam int CYCLE_LIMIT  = 1_000_000;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_W-1:0]        s_tdata;
    logic [1:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int mismatch_count;
    int pending_count;
    int results_seen;
    int inside_seen;
    int truncated_seen;

    int   cycle_count  = 0;
    int   items_sent   = 0;
    int   queries_sent = 0;
    logic steady       = 1'b0;
    logic hold_req     = 1'b0;

    // Vertices the block holds, kept to aim query points at the polygon.
    logic signed [COORD_BITS-1:0] shape_x [$];
    logic signed [COORD_BITS-1:0] shape_y [$];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    point_in_polygon_test_top #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    point_in_polygon_checker #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .results_seen   (results_seen),
        .inside_seen    (inside_seen),
        .truncated_seen (truncated_seen)
    );

    // Run-length guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result receiver: random stalls, a steady stretch and one long hold-off.
    initial
    begin : receiver
        int   hold_left;
        logic hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else if (steady)
                m_tready = 1'b1;
            else
                m_tready = ($urandom_range(0, 99) >= 30);
        end
    end

    // Coordinate for a vertex or query point: full range, a small grid that
    // makes collinear and shared-y cases common, the extremes, or mid range.
    function automatic logic signed [COORD_BITS-1:0] pick_coord(input int mode);
        case (mode)
            0: return COORD_BITS'($urandom);
            1: return COORD_BITS'(int'($urandom_range(0, 16)) - 8);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return C_MIN;
                    1: return C_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return COORD_BITS'(int'($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    // Offers one item at the falling edge and holds it until accepted.
    task automatic send_item(input logic [1:0] op,
                             input logic signed [COORD_BITS-1:0] x,
                             input logic signed [COORD_BITS-1:0] y);
        if (!steady)
        begin
            while ($urandom_range(0, 99) < 30)
            begin
                s_tvalid = 1'b0;
                @(negedge clk);
            end
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = IN_W'({y, x});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        s_tvalid = 1'b0;
        if (op == OP_CLEAR)
        begin
            shape_x.delete();
            shape_y.delete();
        end
        else if (op == OP_APPEND && shape_x.size() < MAX_VERTICES)
        begin
            shape_x.push_back(x);
            shape_y.push_back(y);
        end
        if (op == OP_QUERY)
            queries_sent++;
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    initial
    begin : stimulus
        int   seq_count;
        int   n_verts;
        int   n_queries;
        int   mode;
        int   pick;
        int   a;
        int   b;
        logic pressure_done;
        logic signed [COORD_BITS-1:0] qx;
        logic signed [COORD_BITS-1:0] qy;

        seq_count     = 0;
        pressure_done = 1'b0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_CLEAR;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty polygon, unused code, degenerate polygons with a
        // horizontal edge, a triangle at the coordinate extremes, then a
        // square from -1 to 1 probed at its centre and on its edges.
        send_item(OP_QUERY, 5, 5);
        send_item(OP_UNUSED, '1, '1);
        send_item(OP_APPEND, C_MIN, C_MIN);
        send_item(OP_QUERY, 0, 0);
        send_item(OP_APPEND, C_MAX, C_MIN);
        send_item(OP_QUERY, 0, C_MIN);
        send_item(OP_APPEND, 0, C_MAX);
        send_item(OP_QUERY, 0, 0);
        send_item(OP_QUERY, C_MAX, C_MAX);
        send_item(OP_QUERY, C_MIN, C_MIN);
        send_item(OP_QUERY, C_MIN, 0);
        send_item(OP_QUERY, 0, C_MAX);
        send_item(OP_CLEAR, 0, 0);
        send_item(OP_QUERY, 0, 0);
        send_item(OP_APPEND, -1, -1);
        send_item(OP_APPEND, 1, -1);
        send_item(OP_APPEND, 1, 1);
        send_item(OP_APPEND, -1, 1);
        send_item(OP_QUERY, 0, 0);
        send_item(OP_QUERY, 1, 0);
        send_item(OP_QUERY, -1, 0);
        send_item(OP_QUERY, 0, 1);
        send_item(OP_QUERY, 0, -1);
        send_item(OP_UNUSED, COORD_BITS'($urandom), COORD_BITS'($urandom));
        send_item(OP_CLEAR, 0, 0);

        // Random polygons, each followed by a handful of queries, some aimed at its vertices and edges.
        while (items_sent < TARGET_ITEMS)
        begin
            seq_count++;
            if (seq_count == 30)
            begin
                @(posedge clk);
                steady = 1'b1;
                @(negedge clk);
            end
            if (seq_count == 60)
            begin
                @(posedge clk);
                steady = 1'b0;
                @(negedge clk);
            end

            // Overfilled polygon queried while the receiver holds off, so the
            // output and the input back up; then drain completely.
            if (!pressure_done && items_sent >= TARGET_ITEMS / 2)
            begin
                pressure_done = 1'b1;
                send_item(OP_CLEAR, 0, 0);
                for (int k = 0; k < MAX_VERTICES + 6; k++)
                    send_item(OP_APPEND, pick_coord(0), pick_coord(0));
                @(posedge clk);
                hold_req = 1'b1;
                @(negedge clk);
                for (int k = 0; k < 5; k++)
                    send_item(OP_QUERY, pick_coord(3), pick_coord(3));
                s_tvalid = 1'b0;
                while (pending_count != 0)
                    @(negedge clk);
            end

            if ($urandom_range(0, 99) < 4)
                send_item(OP_UNUSED, COORD_BITS'($urandom), COORD_BITS'($urandom));
            mode = $urandom_range(0, 3);
            if ($urandom_range(0, 99) < 85)
                send_item(OP_CLEAR, COORD_BITS'($urandom), COORD_BITS'($urandom));
            pick = $urandom_range(0, 99);
            if (pick < 80)
                n_verts = $urandom_range(0, 12);
            else if (pick < 92)
                n_verts = $urandom_range(13, 63);
            else
                n_verts = $urandom_range(64, 70);
            for (int k = 0; k < n_verts; k++)
                send_item(OP_APPEND, pick_coord(mode), pick_coord(mode));

            n_queries = $urandom_range(1, 6);
            for (int k = 0; k < n_queries; k++)
            begin
                pick = (shape_x.size() == 0) ? 0 : $urandom_range(0, 4);
                a    = (shape_x.size() == 0) ? 0 : $urandom_range(0, shape_x.size() - 1);
                b    = (shape_x.size() == 0) ? 0 : (a + 1) % shape_x.size();
                case (pick)
                    1:
                    begin
                        qx = shape_x[a];
                        qy = shape_y[a];
                    end
                    2:
                    begin
                        // Same height as a vertex, slightly to either side.
                        qx = shape_x[a] + COORD_BITS'(int'($urandom_range(0, 8)) - 4);
                        qy = shape_y[a];
                    end
                    3:
                    begin
                        // Midpoint of an edge.
                        qx = COORD_BITS'((int'(shape_x[a]) + int'(shape_x[b])) / 2);
                        qy = COORD_BITS'((int'(shape_y[a]) + int'(shape_y[b])) / 2);
                    end
                    4:
                    begin
                        qx = pick_coord(mode);
                        qy = pick_coord(mode);
                    end
                    default:
                    begin
                        qx = COORD_BITS'($urandom);
                        qy = COORD_BITS'($urandom);
                    end
                endcase
                send_item(OP_QUERY, qx, qy);
            end

            // Now and then the sender waits for every answer to come back.
            if ($urandom_range(0, 99) < 5)
            begin
                s_tvalid = 1'b0;
                while (pending_count != 0)
                    @(negedge clk);
            end
        end

        // Drain and let any stray result show up.
        s_tvalid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);

        $display("Sent %0d items with %0d queries, polygons from empty to past the %0d-%s",
                 items_sent, queries_sent, MAX_VERTICES, "vertex capacity.");
        $display("Checked %0d results: %0d inside, %0d with the truncation flag set.",
                 results_seen, inside_seen, truncated_seen);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[point_in_polygon_test_top.f]
sv/pip_pkg.sv
sv/pip_ram.sv
sv/pip_ctrl.sv
sv/pip_datapath.sv
sv/point_in_polygon_test_top.sv
dv/point_in_polygon_checker.sv
dv/point_in_polygon_test_top_tb.sv
